@@ hw/rtl/rth_pkg.sv @@
// rth_pkg: shared constants, types and the CORDIC angle table for the
// RGB to HSI converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rth_pkg;

  localparam int unsigned CordicSteps = 32;
  localparam int unsigned VecBits     = 64;
  localparam int unsigned AngBits     = 34;

  localparam logic signed [VecBits-1:0] Sqrt3Q30    = 64'sd1859775393;
  localparam logic signed [AngBits-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [AngBits-1:0] HalfTurn    = 34'sd2147483648;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [AngBits-1:0] turn_atan(input logic [4:0] idx);
    logic signed [AngBits-1:0] v;
    begin
      case (idx)
        5'd0: v = 34'sd536870912;   5'd1: v = 34'sd316933406;
        5'd2: v = 34'sd167458907;   5'd3: v = 34'sd85004756;
        5'd4: v = 34'sd42667331;    5'd5: v = 34'sd21354465;
        5'd6: v = 34'sd10679838;    5'd7: v = 34'sd5340245;
        5'd8: v = 34'sd2670163;     5'd9: v = 34'sd1335087;
        5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
        5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
        5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
        5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
        5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
        5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
        5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
        5'd24: v = 34'sd41;         5'd25: v = 34'sd20;
        5'd26: v = 34'sd10;         5'd27: v = 34'sd5;
        5'd28: v = 34'sd3;          5'd29: v = 34'sd1;
        5'd30: v = 34'sd1;
        default: v = 34'sd0;
      endcase
      return v;
    end
  endfunction

  // flags that travel alongside the vector through the cell row
  typedef struct packed {
    logic                      equal;    // all channels equal
    logic                      blue_gt;  // blue > green
    logic                      direct;   // angle fixed without CORDIC
    logic signed [AngBits-1:0] base;     // pre-rotation or fixed angle
  } hue_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/rth_stream_if.sv @@
// rth_stream_if: valid/ready channel carrying a packed payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rth_stream_if #(
  parameter int unsigned Width = 24
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rth_cordic_cell.sv @@
// rth_cordic_cell: one vectoring CORDIC iteration and, while Stage < QuotBits,
// one restoring divide step, with their pipeline register. Depends on rth_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rth_cordic_cell #(
  parameter int unsigned Stage    = 0,
  parameter int unsigned SideBits = 16,
  parameter int unsigned NumBits  = 28,
  parameter int unsigned DenBits  = 11,
  parameter int unsigned QuotBits = 17
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic signed [rth_pkg::VecBits-1:0]  x_i,
  input  wire logic signed [rth_pkg::VecBits-1:0]  y_i,
  input  wire logic signed [rth_pkg::AngBits-1:0]  z_i,
  input  wire rth_pkg::hue_ctl_t                   ctl_i,
  input  wire logic [SideBits-1:0]                 side_i,
  input  wire logic [NumBits-1:0]                  num_i,
  input  wire logic [DenBits-1:0]                  den_i,
  input  wire logic [QuotBits-1:0]                 quo_i,
  output logic                                     valid_o,
  output logic signed [rth_pkg::VecBits-1:0]       x_o,
  output logic signed [rth_pkg::VecBits-1:0]       y_o,
  output logic signed [rth_pkg::AngBits-1:0]       z_o,
  output rth_pkg::hue_ctl_t                        ctl_o,
  output logic [SideBits-1:0]                      side_o,
  output logic [NumBits-1:0]                       num_o,
  output logic [DenBits-1:0]                       den_o,
  output logic [QuotBits-1:0]                      quo_o
);
  // quotient bit resolved here; cells past the last quotient bit skip the divide
  localparam bit DoDiv = (int'(Stage) < int'(QuotBits));
  localparam int QBit  = DoDiv ? (int'(QuotBits) - 1 - int'(Stage)) : 0;

  logic signed [rth_pkg::VecBits-1:0] dx, dy, x_d, y_d;
  logic signed [rth_pkg::AngBits-1:0] z_d, a;
  logic [NumBits-1:0] sub, num_d;
  logic [QuotBits-1:0] quo_d;
  logic valid_q;
  logic signed [rth_pkg::VecBits-1:0] x_q, y_q;
  logic signed [rth_pkg::AngBits-1:0] z_q;
  rth_pkg::hue_ctl_t ctl_q;
  logic [SideBits-1:0] side_q;
  logic [NumBits-1:0] num_q;
  logic [DenBits-1:0] den_q;
  logic [QuotBits-1:0] quo_q;

  always_comb begin
    dx = y_i >>> Stage;
    dy = x_i >>> Stage;
    a  = rth_pkg::turn_atan(5'(Stage));
    if (!y_i[rth_pkg::VecBits-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + a;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - a;
    end
  end

  always_comb begin
    sub   = NumBits'(den_i) << QBit;
    num_d = num_i;
    quo_d = quo_i;
    if (DoDiv && (num_i >= sub)) begin
      num_d = num_i - sub;
      quo_d = quo_i | (QuotBits'(1) << QBit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      ctl_q  <= ctl_i;
      side_q <= side_i;
      num_q  <= num_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign ctl_o   = ctl_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
endmodule
`default_nettype wire

@@ hw/rtl/rth_front.sv @@
// rth_front: input register stage; forms the CORDIC start vector, intensity
// and the saturation dividend/divisor. Depends on rth_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rth_front #(
  parameter int unsigned ChannelBits  = 8,
  parameter int unsigned FractionBits = 16,
  parameter int unsigned NumBits      = 28,
  parameter int unsigned DenBits      = 11
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic [ChannelBits-1:0]             red_i,
  input  wire logic [ChannelBits-1:0]             green_i,
  input  wire logic [ChannelBits-1:0]             blue_i,
  output logic                                    valid_o,
  output logic signed [rth_pkg::VecBits-1:0]      x_o,
  output logic signed [rth_pkg::VecBits-1:0]      y_o,
  output rth_pkg::hue_ctl_t                       ctl_o,
  output logic [FractionBits-1:0]                 side_o,
  output logic [NumBits-1:0]                      num_o,
  output logic [DenBits-1:0]                      den_o
);
  localparam int unsigned SumBits = ChannelBits + 2;
  localparam int unsigned WideBits = 64;
  localparam logic [WideBits-1:0] Fone = WideBits'(1) << FractionBits;
  localparam logic [WideBits-1:0] Den  = WideBits'(3) * ((WideBits'(1) << ChannelBits) - 1);
  // intensity = floor(X / InDen) via X * Recip >> RecipShift, exact for X < 2^XBits
  localparam int unsigned XBits      = SumBits + FractionBits + 2;
  localparam int unsigned MBits      = XBits + 2;
  localparam int unsigned ProdBits   = XBits + MBits;
  localparam int unsigned RecipShift = XBits + ChannelBits + 3;
  localparam logic [127:0] InDen = 128'(6) * ((128'(1) << ChannelBits) - 128'(1));
  localparam logic [127:0] Recip = ((128'(1) << RecipShift) + InDen - 128'(1)) / InDen;

  logic [SumBits-1:0] sum, mn;
  logic [XBits-1:0] inten_num;
  logic [ProdBits-1:0] inten_prod;
  logic [FractionBits-1:0] inten;
  logic [NumBits-1:0] num;
  logic [DenBits-1:0] den;
  logic signed [SumBits+1:0] n, d;
  logic signed [rth_pkg::VecBits-1:0] px, py;
  rth_pkg::hue_ctl_t ctl;
  logic valid_q;
  logic signed [rth_pkg::VecBits-1:0] x_q, y_q;
  rth_pkg::hue_ctl_t ctl_q;
  logic [FractionBits-1:0] side_q;
  logic [NumBits-1:0] num_q;
  logic [DenBits-1:0] den_q;

  always_comb begin
    sum = SumBits'(red_i) + SumBits'(green_i) + SumBits'(blue_i);
    mn  = SumBits'(red_i);
    if (SumBits'(green_i) < mn) mn = SumBits'(green_i);
    if (SumBits'(blue_i) < mn) mn = SumBits'(blue_i);
    inten_num  = XBits'(((WideBits'(sum) * (Fone - 1)) << 1) + Den);
    inten_prod = ProdBits'(inten_num) * ProdBits'(Recip[MBits-1:0]);
    inten      = inten_prod[RecipShift +: FractionBits];
    ctl.equal   = (red_i == green_i) && (green_i == blue_i);
    ctl.blue_gt = blue_i > green_i;
    n = (SumBits+2)'(2 * red_i) - (SumBits+2)'(green_i) - (SumBits+2)'(blue_i);
    d = (green_i > blue_i) ? (SumBits+2)'(green_i - blue_i) : (SumBits+2)'(blue_i - green_i);
    px = rth_pkg::VecBits'(n) <<< 30;
    py = rth_pkg::VecBits'(d) * rth_pkg::Sqrt3Q30;
    ctl.direct = (d == 0) || ctl.equal;
    ctl.base   = '0;
    if (ctl.direct) begin
      ctl.base = (n > 0 || ctl.equal) ? '0 : rth_pkg::HalfTurn;
    end
    if (px < 0) begin
      ctl.base = ctl.direct ? ctl.base : rth_pkg::QuarterTurn;
    end
    // saturation dividend 2*(sum-3*min)*2^F + sum over divisor 2*sum; 0/1 when equal
    if (ctl.equal) begin
      num = '0;
      den = DenBits'(1);
    end else begin
      num = ((NumBits'(sum) - NumBits'(mn) * NumBits'(3)) << (FractionBits + 1)) +
            NumBits'(sum);
      den = DenBits'(sum) << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= (px < 0) ? py : px;
      y_q    <= (px < 0) ? -px : py;
      ctl_q  <= ctl;
      side_q <= inten;
      num_q  <= num;
      den_q  <= den;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ctl_o   = ctl_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
endmodule
`default_nettype wire

@@ hw/rtl/rgb_to_hsi_converter.sv @@
// rgb_to_hsi_converter: top level; front stage, a row of 32 CORDIC cells
// and an output stage. Depends on rth_pkg, rth_stream_if, rth_front, rth_cordic_cell.
//
// Usage:
//   in_if  (sink):   payload {blue, green, red}, one pixel per beat.
//   out_if (source): payload {intensity, saturation, hue}, one result per beat.
//   Throughput: one pixel per clock while out_if.ready is high or the output
//   stage is empty. Each pixel passes the front register, 32 CORDIC cells and
//   the output register in turn before its output beat.
//   Saturation is divided alongside, one quotient bit per cell in the first
//   FRACTION_BITS+1 cells.
//   The whole pipeline advances together; when the receiver holds ready low
//   while a result waits, the row freezes and in_if.ready drops. Bubbles
//   move along so an empty output stage still accepts new pixels.
//   Reset clears all valid bits; no item is in flight afterward.
//   Hue and saturation are zero when all channels are equal.
//   Intensity is the rounded channel mean; saturation 1 - 3*min/sum.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsi_converter #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rth_stream_if.sink   in_if,
  rth_stream_if.source out_if
);
  localparam int unsigned N = rth_pkg::CordicSteps;
  localparam int unsigned SideBits = FRACTION_BITS;
  localparam int unsigned Sh = 32 - FRACTION_BITS;
  localparam int unsigned SumBits  = CHANNEL_BITS + 2;
  localparam int unsigned NumBits  = SumBits + FRACTION_BITS + 2;
  localparam int unsigned DenBits  = SumBits + 1;
  localparam int unsigned QuotBits = FRACTION_BITS + 1;

  logic en;
  logic                               v   [N+1];
  logic signed [rth_pkg::VecBits-1:0] x   [N+1];
  logic signed [rth_pkg::VecBits-1:0] y   [N+1];
  logic signed [rth_pkg::AngBits-1:0] z   [N+1];
  rth_pkg::hue_ctl_t                  c   [N+1];
  logic [SideBits-1:0]                s   [N+1];
  logic [NumBits-1:0]                 num [N+1];
  logic [DenBits-1:0]                 den [N+1];
  logic [QuotBits-1:0]                quo [N+1];

  logic out_valid_q;
  logic [FRACTION_BITS-1:0] hue_q, inten_q;
  logic [FRACTION_BITS:0]   sat_q;
  logic signed [rth_pkg::AngBits-1:0] zc, h;
  logic [rth_pkg::AngBits:0] hu, hr;
  logic [FRACTION_BITS-1:0] hue_d;

  assign en = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  rth_front #(
    .ChannelBits(CHANNEL_BITS), .FractionBits(FRACTION_BITS),
    .NumBits(NumBits), .DenBits(DenBits)
  ) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid),
    .red_i(in_if.data[CHANNEL_BITS-1:0]),
    .green_i(in_if.data[2*CHANNEL_BITS-1:CHANNEL_BITS]),
    .blue_i(in_if.data[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
    .valid_o(v[0]), .x_o(x[0]), .y_o(y[0]), .ctl_o(c[0]), .side_o(s[0]),
    .num_o(num[0]), .den_o(den[0])
  );
  assign z[0]   = '0;
  assign quo[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rth_cordic_cell #(
      .Stage(i), .SideBits(SideBits), .NumBits(NumBits), .DenBits(DenBits),
      .QuotBits(QuotBits)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v[i]),
      .x_i(x[i]), .y_i(y[i]), .z_i(z[i]), .ctl_i(c[i]), .side_i(s[i]),
      .num_i(num[i]), .den_i(den[i]), .quo_i(quo[i]),
      .valid_o(v[i+1]), .x_o(x[i+1]), .y_o(y[i+1]), .z_o(z[i+1]),
      .ctl_o(c[i+1]), .side_o(s[i+1]),
      .num_o(num[i+1]), .den_o(den[i+1]), .quo_o(quo[i+1])
    );
  end

  always_comb begin
    zc = z[N];
    if (zc < 0) zc = '0;
    if (zc > rth_pkg::QuarterTurn) zc = rth_pkg::QuarterTurn;
    h = c[N].direct ? c[N].base : c[N].base + zc;
    hu = (rth_pkg::AngBits+1)'(h);
    if (c[N].blue_gt) hu = (rth_pkg::AngBits+1)'(35'h1_0000_0000) - hu;
    hr = (hu + ((rth_pkg::AngBits+1)'(1) << (Sh - 1))) >> Sh;
    hue_d = (hr > (rth_pkg::AngBits+1)'((36'h1 << FRACTION_BITS) - 1)) ? '1
            : hr[FRACTION_BITS-1:0];
    if (c[N].equal) hue_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q   <= hue_d;
      inten_q <= s[N];
      sat_q   <= quo[N];
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = {inten_q, sat_q, hue_q};
endmodule
`default_nettype wire

@@ hw/rtl/rth_checker.sv @@
// rth_checker: port-level assertions for rgb_to_hsi_converter, bound to it.
// Depends on rth_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module rth_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("stall without result");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("took beat while stalled");
endmodule

bind rgb_to_hsi_converter rth_checker u_rth_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready)
);
`default_nettype wire

@@ tb/hsi_checker.sv @@
// hsi_checker: watches the pixel and result channels of the RGB to HSI converter,
// predicts every result and compares it. Depends on rth_stream_if.
`timescale 1ns / 1ps
module hsi_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  rth_stream_if  in_if,
  rth_stream_if  out_if,
  output int     fail_count_o,
  output int     pending_o
);

  typedef struct {
    logic [15:0] hue;
    logic [16:0] sat;
    logic [15:0] inten;
  } hsi_t;

  localparam longint AtanTurns[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };
  localparam longint Quarter = 64'd1073741824;
  localparam longint Half    = 64'd2147483648;
  localparam longint Sqrt3   = 64'd1859775393;

  hsi_t expected_q[$];
  int   mismatches;

  // angle of (px, py), py >= 0, in 2^-32 turn units
  function automatic longint vector_angle(longint px, longint py);
    longint x, y, z, base, dx, dy;
    z = 0;
    base = 0;
    if (px < 0) begin
      x = py;
      y = -px;
      base = Quarter;
    end else begin
      x = px;
      y = py;
    end
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += AtanTurns[i];
      end else begin
        x -= dx;
        y += dy;
        z -= AtanTurns[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Quarter) z = Quarter;
    return base + z;
  endfunction

  function automatic hsi_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    hsi_t   res;
    longint r, g, b, sum, mn, n, d, h, hv;
    r = r8;
    g = g8;
    b = b8;
    sum = r + g + b;
    res.inten = 16'((2 * sum * 65535 + 765) / 1530);
    if (r == g && g == b) begin
      res.hue = '0;
      res.sat = '0;
    end else begin
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      res.sat = 17'(((2 * (sum - 3 * mn)) * 65536 + sum) / (2 * sum));
      n = 2 * r - g - b;
      d = (g > b) ? g - b : b - g;
      if (d == 0) h = (n > 0) ? 0 : Half;
      else h = vector_angle(n * Quarter, d * Sqrt3);
      if (b > g) h = (64'd1 << 32) - h;
      hv = (h + (64'd1 << 15)) >> 16;
      if (hv > 65535) hv = 65535;
      res.hue = 16'(hv);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hsi_t exp_v, got;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      mismatches = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_q.push_back(convert_pixel(in_if.data[7:0], in_if.data[15:8],
                                           in_if.data[23:16]));
      if (out_if.valid && out_if.ready) begin
        got.hue   = out_if.data[15:0];
        got.sat   = out_if.data[32:16];
        got.inten = out_if.data[48:33];
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (mismatches < 10)
            $display("unexpected result beat hue=%0d sat=%0d int=%0d",
                     got.hue, got.sat, got.inten);
          mismatches++;
        end else begin
          exp_v = expected_q.pop_front();
          if (got.hue !== exp_v.hue || got.sat !== exp_v.sat ||
              got.inten !== exp_v.inten) begin
            fail_count_o <= fail_count_o + 1;
            if (mismatches < 10)
              $display("mismatch: exp hue=%0d sat=%0d int=%0d, got hue=%0d sat=%0d int=%0d",
                       exp_v.hue, exp_v.sat, exp_v.inten, got.hue, got.sat, got.inten);
            mismatches++;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// testbench: drives pixels into the RGB to HSI converter with random gaps and
// backpressure. Depends on rth_pkg, rth_stream_if, rgb_to_hsi_converter, hsi_checker.
`timescale 1ns / 1ps
module testbench;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   stall_mode;

  rth_stream_if #(.Width(24)) in_if ();
  rth_stream_if #(.Width(49)) out_if ();

  rgb_to_hsi_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  hsi_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .out_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // one beat; holds valid high if no gap follows
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = (stall_mode == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = {b, g, r};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // receiver backpressure, with stretches of full speed
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_mode == 0) out_if.ready = 1'b1;
      else if ($urandom_range(0, 99) < 5) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end else out_if.ready = ($urandom_range(0, 99) < 80);
    end
  end

  initial begin
    logic [7:0] r, g, b;
    int         kind;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    stall_mode  = 1;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(200, 50, 50);    // green equals blue, red above
    send_pixel(10, 50, 50);     // green equals blue, red below
    send_pixel(255, 0, 1);      // hue near a full turn
    send_pixel(255, 1, 0);
    send_pixel(1, 0, 0);
    send_pixel(0, 0, 1);
    send_pixel(254, 255, 255);
    send_pixel(85, 170, 255);
    send_pixel(170, 85, 0);

    for (int i = 0; i < 1530; i++) begin
      if (i == 300) begin
        // drain fully before resuming
        in_if.valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      stall_mode = (i >= 600 && i < 800) ? 0 : 1;
      kind = $urandom_range(0, 9);
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      if (kind == 0) begin
        g = r; b = r;
      end else if (kind == 1) begin
        b = g;
      end else if (kind == 2) begin
        g = 8'(r + $urandom_range(0, 2) - 1);
        b = 8'(r + $urandom_range(0, 2) - 1);
      end else if (kind == 3) begin
        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        g = $urandom_range(0, 1) ? 8'hff : 8'h00;
        b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      send_pixel(r, g, b);
    end
    in_if.valid = 1'b0;
    stall_mode = 1;

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rth_pkg.sv
hw/rtl/rth_stream_if.sv
hw/rtl/rth_cordic_cell.sv
hw/rtl/rth_front.sv
hw/rtl/rgb_to_hsi_converter.sv
hw/rtl/rth_checker.sv
tb/hsi_checker.sv
tb/testbench.sv
